// File: hw/rtl/minmax_uniform_quantizer_defines.svh
// Assertion helpers for the min/max quantizer.
// Both forms assume signals named clk and rst_n in the using scope.
`ifndef MINMAX_UNIFORM_QUANTIZER_DEFINES_SVH
`define MINMAX_UNIFORM_QUANTIZER_DEFINES_SVH

`ifndef SYNTHESIS

`define MMQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mmq: same-cycle check failed");

`define MMQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mmq: next-cycle check failed");

`else

`define MMQ_ASSERT_IMP(lbl, ante, cons)

`define MMQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hw/rtl/mmq_pkg.sv
package mmq_pkg;

  localparam int SAMPLE_W = 32;
  localparam int SPAN_W   = SAMPLE_W + 1;
  localparam int EXP_W    = 4;
  localparam int LVL_W    = 12;
  localparam int KQ_W     = LVL_W + 1;
  localparam int ZONE_W   = 6;
  localparam int PROD_W   = SPAN_W + KQ_W;

  localparam logic [EXP_W-1:0] EXP_MIN = 4'd1;
  localparam logic [EXP_W-1:0] EXP_MAX = 4'd12;
  localparam logic [EXP_W-1:0] EXP_RST = 4'd4;

  // one closed set, handed from the loader to the emitter
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic                       ovf;
    logic [EXP_W-1:0]           exp;
    logic                       bank;
  } job_t;

endpackage

// File: hw/rtl/minmax_uniform_quantizer.sv
// Min/max uniform quantizer.
// Input: pulse start with in_sample/in_last_in while busy is low; the item is
// taken at that edge. Samples of a set go into a two-bank store (MAX_ZONES
// per bank) while the running min and max are kept. The item with in_last_in
// set closes the set and queues it for emission; samples past capacity are
// dropped and flagged on every result of that set.
// Output: one result per stored sample, in load order, each shown for a
// single cycle with out_strobe high; out_last_out marks the last of a set.
// The receiver cannot stall the block.
// Loading takes a new sample whenever busy is low. Each result passes through the
// states RD, INIT, DIV, CALC, MUL and EMIT (DIV is skipped for a flat set); the
// level index comes from a restoring divider that yields one quotient bit per cycle,
// followed by a multiply step, using the clamped level exponent. Each set adds the
// IDLE and SETUP states before its first result.
// A new set loads while the previous one emits; busy rises only when one set
// is emitting and another is waiting.
// cfg_we/cfg_level_exponent write the exponent (reset value 4); write only
// while idle. Reset empties the store, queue and emitter.
module minmax_uniform_quantizer #(
  parameter int MAX_ZONES = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [mmq_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_last_in,
  input  logic                                cfg_we,
  input  logic [mmq_pkg::EXP_W-1:0]           cfg_level_exponent,
  output logic                                out_strobe,
  output logic [mmq_pkg::ZONE_W-1:0]          out_zone_number,
  output logic signed [mmq_pkg::SAMPLE_W-1:0] out_sample_echo,
  output logic [mmq_pkg::LVL_W-1:0]           out_level_index,
  output logic signed [mmq_pkg::SAMPLE_W-1:0] out_level_value,
  output logic                                out_dropped_flag,
  output logic                                out_last_out
);

  localparam int IDX_W = $clog2(MAX_ZONES);
  localparam int CNT_W = $clog2(MAX_ZONES + 1);
  localparam int DEPTH = 2 * (2 ** IDX_W);

  logic                         ram_we;
  logic [IDX_W:0]               ram_waddr, ram_raddr;
  logic [mmq_pkg::SAMPLE_W-1:0] ram_wdata, ram_rdata;
  logic                         push, pop, avail, done;
  mmq_pkg::job_t                push_job, pop_job;
  logic [IDX_W-1:0]             push_last, pop_last;

  mmq_front #(
    .MAX_ZONES (MAX_ZONES),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .sample    (in_sample),
    .last_in   (in_last_in),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_level_exponent),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .push      (push),
    .push_job  (push_job),
    .push_last (push_last),
    .done      (done)
  );

  mmq_ram #(
    .WIDTH (mmq_pkg::SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mmq_queue #(
    .IDX_W (IDX_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .push_last (push_last),
    .avail     (avail),
    .pop       (pop),
    .pop_job   (pop_job),
    .pop_last  (pop_last)
  );

  mmq_back #(
    .IDX_W (IDX_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .avail            (avail),
    .pop              (pop),
    .job              (pop_job),
    .job_last         (pop_last),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .done             (done),
    .out_strobe       (out_strobe),
    .out_zone_number  (out_zone_number),
    .out_sample_echo  (out_sample_echo),
    .out_level_index  (out_level_index),
    .out_level_value  (out_level_value),
    .out_dropped_flag (out_dropped_flag),
    .out_last_out     (out_last_out)
  );

endmodule

// File: hw/rtl/mmq_ram.sv
module mmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/mmq_front.sv
module mmq_front #(
  parameter int MAX_ZONES = 64,
  parameter int IDX_W     = 6,
  parameter int CNT_W     = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [mmq_pkg::SAMPLE_W-1:0] sample,
  input  logic                                last_in,
  input  logic                                cfg_we,
  input  logic [mmq_pkg::EXP_W-1:0]           cfg_wdata,
  output logic                                ram_we,
  output logic [IDX_W:0]                      ram_waddr,
  output logic [mmq_pkg::SAMPLE_W-1:0]        ram_wdata,
  output logic                                push,
  output mmq_pkg::job_t                       push_job,
  output logic [IDX_W-1:0]                    push_last,
  input  logic                                done
);

  logic [CNT_W-1:0]                    count_r, count_nxt, count_set;
  logic signed [mmq_pkg::SAMPLE_W-1:0] lo_r, lo_nxt, lo_set;
  logic signed [mmq_pkg::SAMPLE_W-1:0] hi_r, hi_nxt, hi_set;
  logic                                ovf_r, ovf_nxt, ovf_set;
  logic                                bank_r, bank_nxt;
  logic [mmq_pkg::EXP_W-1:0]           exp_r, exp_nxt, exp_eff;
  logic [1:0]                          jobs_r, jobs_nxt;
  logic                                accept, full, first;

  // two store banks: at most two sets in flight (one emitting, one queued)
  assign busy   = (jobs_r == 2'd2);
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(MAX_ZONES));
  assign first  = (count_r == '0);

  assign ram_we    = accept && !full;
  assign ram_waddr = {bank_r, count_r[IDX_W-1:0]};
  assign ram_wdata = sample;

  always_comb begin
    if (exp_r < mmq_pkg::EXP_MIN) begin
      exp_eff = mmq_pkg::EXP_MIN;
    end else if (exp_r > mmq_pkg::EXP_MAX) begin
      exp_eff = mmq_pkg::EXP_MAX;
    end else begin
      exp_eff = exp_r;
    end
  end

  always_comb begin
    count_set = count_r;
    lo_set    = lo_r;
    hi_set    = hi_r;
    ovf_set   = ovf_r;
    if (full) begin
      ovf_set = 1'b1;
    end else begin
      count_set = count_r + CNT_W'(1);
      if (first || (sample < lo_r)) begin
        lo_set = sample;
      end
      if (first || (sample > hi_r)) begin
        hi_set = sample;
      end
    end
  end

  assign push          = accept && last_in;
  assign push_job.lo   = lo_set;
  assign push_job.hi   = hi_set;
  assign push_job.ovf  = ovf_set;
  assign push_job.exp  = exp_eff;
  assign push_job.bank = bank_r;
  assign push_last     = IDX_W'(count_set - CNT_W'(1));

  always_comb begin
    count_nxt = count_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    ovf_nxt   = ovf_r;
    bank_nxt  = bank_r;
    if (accept) begin
      if (last_in) begin
        count_nxt = '0;
        lo_nxt    = '0;
        hi_nxt    = '0;
        ovf_nxt   = 1'b0;
        bank_nxt  = !bank_r;
      end else begin
        count_nxt = count_set;
        lo_nxt    = lo_set;
        hi_nxt    = hi_set;
        ovf_nxt   = ovf_set;
      end
    end
  end

  assign exp_nxt  = cfg_we ? cfg_wdata : exp_r;
  assign jobs_nxt = jobs_r + {1'b0, push} - {1'b0, done};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      lo_r    <= '0;
      hi_r    <= '0;
      ovf_r   <= 1'b0;
      bank_r  <= 1'b0;
      exp_r   <= mmq_pkg::EXP_RST;
      jobs_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      ovf_r   <= ovf_nxt;
      bank_r  <= bank_nxt;
      exp_r   <= exp_nxt;
      jobs_r  <= jobs_nxt;
    end
  end

endmodule

// File: hw/rtl/mmq_queue.sv
module mmq_queue #(
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mmq_pkg::job_t    push_job,
  input  logic [IDX_W-1:0] push_last,
  output logic             avail,
  input  logic             pop,
  output mmq_pkg::job_t    pop_job,
  output logic [IDX_W-1:0] pop_last
);

  mmq_pkg::job_t    job_q_r  [2];
  logic [IDX_W-1:0] last_q_r [2];
  logic             wr_r, wr_nxt;
  logic             rd_r, rd_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign avail    = (cnt_r != 2'd0);
  assign pop_job  = job_q_r[rd_r];
  assign pop_last = last_q_r[rd_r];

  assign wr_nxt  = push ? !wr_r : wr_r;
  assign rd_nxt  = pop ? !rd_r : rd_r;
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (push) begin
      job_q_r[wr_r]  <= push_job;
      last_q_r[wr_r] <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/mmq_back.sv
`include "minmax_uniform_quantizer_defines.svh"

module mmq_back #(
  parameter int IDX_W = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                avail,
  output logic                                pop,
  input  mmq_pkg::job_t                       job,
  input  logic [IDX_W-1:0]                    job_last,
  output logic [IDX_W:0]                      ram_raddr,
  input  logic [mmq_pkg::SAMPLE_W-1:0]        ram_rdata,
  output logic                                done,
  output logic                                out_strobe,
  output logic [mmq_pkg::ZONE_W-1:0]          out_zone_number,
  output logic signed [mmq_pkg::SAMPLE_W-1:0] out_sample_echo,
  output logic [mmq_pkg::LVL_W-1:0]           out_level_index,
  output logic signed [mmq_pkg::SAMPLE_W-1:0] out_level_value,
  output logic                                out_dropped_flag,
  output logic                                out_last_out
);

  localparam int SW = mmq_pkg::SAMPLE_W;
  localparam int PW = mmq_pkg::SPAN_W;
  localparam int KW = mmq_pkg::KQ_W;
  localparam int LW = mmq_pkg::LVL_W;
  localparam int XW = mmq_pkg::PROD_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_INIT  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_CALC  = 3'd5;
  localparam logic [2:0] ST_MUL   = 3'd6;
  localparam logic [2:0] ST_EMIT  = 3'd7;

  logic [2:0]                  state_r, state_nxt;
  logic signed [SW-1:0]        lo_r;
  logic [PW-1:0]               span_r, top_r, off_r, rem_r;
  logic [mmq_pkg::EXP_W-1:0]   exp_r, step_r;
  logic                        bank_r, ovf_r;
  logic [IDX_W-1:0]            last_r, idx_r;
  logic [KW-1:0]               q_r;
  logic [LW-1:0]               k_r;
  logic [XW-1:0]               prod_r;
  logic signed [SW-1:0]        s_r;

  logic                        strobe_r;
  logic [mmq_pkg::ZONE_W-1:0]  zone_r;
  logic signed [SW-1:0]        echo_r, val_r;
  logic [LW-1:0]               index_r;
  logic                        drop_r, lastf_r;

  logic [mmq_pkg::EXP_W:0]     exp1;
  logic [KW-1:0]               lmax;
  logic [PW-1:0]               off_c;
  logic [PW:0]                 rem2;
  logic                        ge;
  logic                        final_item;

  assign exp1       = {1'b0, exp_r} + 5'd1;
  assign lmax       = (KW'(1) << exp_r) - KW'(1);
  assign off_c      = {ram_rdata[SW-1], ram_rdata} - {lo_r[SW-1], lo_r};
  assign rem2       = {rem_r, 1'b0};
  assign ge         = (rem2 >= {1'b0, span_r});
  assign final_item = (idx_r == last_r);

  assign pop       = (state_r == ST_IDLE) && avail;
  assign done      = (state_r == ST_EMIT) && final_item;
  assign ram_raddr = {bank_r, idx_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (avail) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_INIT;
      ST_INIT:  state_nxt = (span_r == '0) ? ST_CALC : ST_DIV;
      ST_DIV:   if (step_r == 4'd1) state_nxt = ST_CALC;
      ST_CALC:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_EMIT;
      ST_EMIT:  state_nxt = final_item ? ST_IDLE : ST_RD;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath; quotient k = floor(off*2^e/span) built one bit per DIV cycle
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (avail) begin
          lo_r   <= job.lo;
          span_r <= {job.hi[SW-1], job.hi} - {job.lo[SW-1], job.lo};
          exp_r  <= job.exp;
          bank_r <= job.bank;
          ovf_r  <= job.ovf;
          last_r <= job_last;
          idx_r  <= '0;
        end
      end
      ST_SETUP: begin
        // centre of the top level: floor(span*(2L-1)/(2L))
        top_r <= PW'((({{(XW-PW){1'b0}}, span_r} << exp1)
                      - {{(XW-PW){1'b0}}, span_r}) >> exp1);
      end
      ST_INIT: begin
        s_r   <= ram_rdata;
        off_r <= off_c;
        if (span_r == '0) begin
          q_r <= '0;
        end else begin
          q_r    <= KW'(off_c >= span_r);
          rem_r  <= (off_c >= span_r) ? (off_c - span_r) : off_c;
          step_r <= exp_r;
        end
      end
      ST_DIV: begin
        rem_r  <= ge ? PW'(rem2 - {1'b0, span_r}) : PW'(rem2);
        q_r    <= {q_r[KW-2:0], ge};
        step_r <= step_r - 4'd1;
      end
      ST_CALC: begin
        k_r <= ((off_r > top_r) || (q_r > lmax)) ? lmax[LW-1:0] : q_r[LW-1:0];
      end
      ST_MUL: begin
        prod_r <= {{(XW-PW){1'b0}}, span_r} * {{(XW-KW){1'b0}}, k_r, 1'b1};
      end
      ST_EMIT: begin
        zone_r  <= mmq_pkg::ZONE_W'(idx_r);
        echo_r  <= s_r;
        index_r <= k_r;
        val_r   <= lo_r + SW'(prod_r >> exp1);
        drop_r  <= ovf_r;
        lastf_r <= final_item;
        if (!final_item) begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == ST_EMIT);
    end
  end

  assign out_strobe       = strobe_r;
  assign out_zone_number  = zone_r;
  assign out_sample_echo  = echo_r;
  assign out_level_index  = index_r;
  assign out_level_value  = val_r;
  assign out_dropped_flag = drop_r;
  assign out_last_out     = lastf_r;

  `MMQ_ASSERT_IMP(a_rem_below_span, state_r == ST_DIV, rem_r < span_r)
  `MMQ_ASSERT_IMP(a_index_in_range, strobe_r, {1'b0, index_r} <= lmax)
  `MMQ_ASSERT_NEXT(a_final_closes, done, (state_r == ST_IDLE) && strobe_r && out_last_out)

endmodule
